/* design/ordered_list_delete_by_key_macros.svh */
// Assertion macros for the checker file of the ordered list block
`ifndef ORDERED_LIST_DELETE_BY_KEY_MACROS_SVH
`define ORDERED_LIST_DELETE_BY_KEY_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while reset is held
`define OLIST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OLIST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/olist_pkg.sv */
// Shared constants, codes and types of the ordered list block
package olist_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;

    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_DUMP      = 3'd5;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic signed [31:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic               emit;
        logic [2:0]         status;
        logic [IDX_W-1:0]   pos;
        logic signed [31:0] val;
        logic [CNT_W-1:0]   cnt;
        logic               last;
    } t_result;

endpackage

/* design/olist_mem.sv */
// Entry store: one write port, one registered read port
module olist_mem
    import olist_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_req           i_req,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/olist_ctrl.sv */
// Sequencer: append, search-and-compact delete, and dump over the entry store
module olist_ctrl
    import olist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_rdata,
    output logic               o_busy,
    output t_mem_req           o_req,
    output t_result            o_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DUMP  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [31:0] r_key, n_key;
    logic [CNT_W-1:0]   r_k, n_k;       // read issue counter (search order / dump index)
    logic               r_cv, n_cv;     // read data valid this cycle
    logic [IDX_W-1:0]   r_ca, n_ca;     // address of the returning read
    logic [CNT_W-1:0]   r_ck, n_ck;     // issue order of the returning read
    logic [CNT_W-1:0]   r_sp, n_sp;     // compaction read pointer
    logic [IDX_W-1:0]   r_hit, n_hit;
    logic signed [31:0] r_removed, n_removed;

    logic [CNT_W-1:0]   w_cnt_m1;
    logic [CNT_W-1:0]   w_k_m1;
    logic               w_rd_en;

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_k_m1   = r_k - CNT_W'(1);
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_k       = r_k;
        n_cv      = 1'b0;
        n_ca      = r_ca;
        n_ck      = r_ck;
        n_sp      = r_sp;
        n_hit     = r_hit;
        n_removed = r_removed;
        w_rd_en   = 1'b0;
        o_req     = '0;
        o_res     = '0;
        o_res.cnt = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = i_value;
                    n_k   = '0;
                    unique case (i_mode)
                        MODE_APPEND: begin
                            o_res.emit = 1'b1;
                            o_res.last = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_req.we     = 1'b1;
                                o_req.waddr  = r_count[IDX_W-1:0];
                                o_req.wdata  = i_value;
                                n_count      = r_count + CNT_W'(1);
                                o_res.status = ST_APPENDED;
                                o_res.pos    = r_count[IDX_W-1:0];
                                o_res.cnt    = n_count;
                            end
                        end
                        MODE_DELETE, MODE_DUMP: begin
                            if (r_count == '0) begin
                                o_res.emit   = 1'b1;
                                o_res.last   = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else if (i_mode == MODE_DELETE) begin
                                n_state = S_FIND;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // unused mode: no result
                        end
                    endcase
                end
            end

            S_FIND: begin
                // search order: head, tail, then entries from the head onward
                w_rd_en = (r_k < r_count);
                if (r_k == '0) begin
                    o_req.raddr = '0;
                end else if (r_k == CNT_W'(1)) begin
                    o_req.raddr = w_cnt_m1[IDX_W-1:0];
                end else begin
                    o_req.raddr = w_k_m1[IDX_W-1:0];
                end
                o_req.re = w_rd_en;
                if (w_rd_en) begin
                    n_k = r_k + CNT_W'(1);
                end
                n_cv = w_rd_en;
                n_ca = o_req.raddr;
                n_ck = r_k;
                if (r_cv && (i_rdata == r_key)) begin
                    n_state   = S_SHIFT;
                    n_hit     = r_ca;
                    n_sp      = CNT_W'(r_ca) + CNT_W'(1);
                    n_removed = i_rdata;
                    n_cv      = 1'b0;
                end else if (r_cv && (r_ck == w_cnt_m1)) begin
                    n_state      = S_IDLE;
                    o_res.emit   = 1'b1;
                    o_res.last   = 1'b1;
                    o_res.status = ST_NOT_FOUND;
                end
            end

            S_SHIFT: begin
                // read the next entry while writing the previous read, entry i+1, into entry i
                w_rd_en     = (r_sp < r_count);
                o_req.re    = w_rd_en;
                o_req.raddr = r_sp[IDX_W-1:0];
                if (w_rd_en) begin
                    n_sp = r_sp + CNT_W'(1);
                end
                n_cv = w_rd_en;
                n_ca = o_req.raddr;
                if (r_cv) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_ca - IDX_W'(1);
                    o_req.wdata = i_rdata;
                end
                if (!w_rd_en && !r_cv) begin
                    n_state      = S_IDLE;
                    n_count      = w_cnt_m1;
                    o_res.emit   = 1'b1;
                    o_res.last   = 1'b1;
                    o_res.status = ST_DELETED;
                    o_res.pos    = r_hit;
                    o_res.val    = r_removed;
                    o_res.cnt    = w_cnt_m1;
                end
            end

            S_DUMP: begin
                w_rd_en     = (r_k < r_count);
                o_req.re    = w_rd_en;
                o_req.raddr = r_k[IDX_W-1:0];
                if (w_rd_en) begin
                    n_k = r_k + CNT_W'(1);
                end
                n_cv = w_rd_en;
                n_ca = o_req.raddr;
                n_ck = r_k;
                if (r_cv) begin
                    o_res.emit   = 1'b1;
                    o_res.status = ST_DUMP;
                    o_res.pos    = r_ca;
                    o_res.val    = i_rdata;
                    o_res.last   = (r_ck == w_cnt_m1);
                    if (r_ck == w_cnt_m1) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cv    <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_k       <= n_k;
        r_ca      <= n_ca;
        r_ck      <= n_ck;
        r_sp      <= n_sp;
        r_hit     <= n_hit;
        r_removed <= n_removed;
    end

endmodule

/* design/ordered_list_delete_by_key.sv */
// Ordered list with append, delete by key and dump; results leave through registers.
// Append, and any empty or full case: one result, in the cycle after the item; unused mode: none.
// Delete: search reads head, tail, then from the head, one per cycle; on a match the later
//   entries move down one place and one deleted result follows, else one not-found result.
// Dump: one result per entry, one per cycle, from the head to the tail. The next item is taken at
//   the edge that takes the last result. Sync active-low reset empties the list, not the store.
module ordered_list_delete_by_key
    import olist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [3:0]         o_position,
    output logic signed [31:0] o_entry_value,
    output logic [4:0]         o_entry_count,
    output logic               o_last
);

    t_mem_req           w_req;
    t_result            w_res;
    logic signed [31:0] w_rdata;

    logic               r_strobe;
    logic [2:0]         r_status;
    logic [3:0]         r_position;
    logic signed [31:0] r_value;
    logic [4:0]         r_count;
    logic               r_last;

    olist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_value (i_value),
        .i_rdata (w_rdata),
        .o_busy  (busy),
        .o_req   (w_req),
        .o_res   (w_res)
    );

    olist_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= w_res.status;
        r_position <= 4'(w_res.pos);
        r_value    <= w_res.val;
        r_count    <= 5'(w_res.cnt);
        r_last     <= w_res.last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_value = r_value;
    assign o_entry_count = r_count;
    assign o_last        = r_last;

endmodule

/* design/olist_chk.sv */
// Port-level checker for the ordered list block, bound to the top level
`include "ordered_list_delete_by_key_macros.svh"

module olist_chk
    import olist_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_mode,
    input logic signed [31:0] i_value,
    input logic               o_strobe,
    input logic [2:0]         o_status,
    input logic [3:0]         o_position,
    input logic signed [31:0] o_entry_value,
    input logic [4:0]         o_entry_count,
    input logic               o_last
);

    // leaving a multi-cycle operation always delivers its final item
    `OLIST_ASSERT_IMP(a_busy_end_last, $fell(busy), o_strobe && o_last, "busy fell without final item")

    // append answers in the next cycle with a single final item
    `OLIST_ASSERT_NXT(a_append_one, start && !busy && (i_mode == MODE_APPEND), o_strobe && o_last && (o_status == ST_APPENDED || o_status == ST_FULL), "append result missing")

    // only dump produces more than one item
    `OLIST_ASSERT_IMP(a_multi_dump, o_strobe && !o_last, o_status == ST_DUMP, "non-final item outside dump")

    // an appended entry sits at the new tail
    `OLIST_ASSERT_IMP(a_append_tail, o_strobe && (o_status == ST_APPENDED), (5'(o_position) + 5'd1) == o_entry_count, "append position off tail")

endmodule

bind ordered_list_delete_by_key olist_chk u_olist_chk (.*);
